[hdl/assert_macros.svh]
// Assertion macros used by the RTL of the coverage selector.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked property check, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

[hdl/bdc_pkg.sv]
// Package for the best-display-by-coverage selector: payload types,
// register indexes and the candidate compare function. No dependencies.
`timescale 1ns / 1ps

package bdc_pkg;

  localparam int MAX_CRTC    = 4;
  localparam int IDX_W       = 2;
  localparam int COORD_W     = 16;
  localparam int EDGE_W      = 18;
  localparam int AREA_W      = 32;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int PRIMARY_W   = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_GEOM_0  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLED = 8'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_POWERED = 8'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_PRIMARY = 8'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_OWNED   = 8'd7;

  localparam logic [PRIMARY_W-1:0] PRIMARY_NONE = 3'd4;

  typedef struct packed {
    logic signed [COORD_W-1:0] rect_left;
    logic signed [COORD_W-1:0] rect_right;
    logic signed [COORD_W-1:0] rect_top;
    logic signed [COORD_W-1:0] rect_bottom;
  } bdc_in_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] chosen_index;
  } bdc_out_t;

  // Layout of one geometry register: height on top, x at the bottom.
  typedef struct packed {
    logic        [COORD_W-1:0] height;
    logic        [COORD_W-1:0] width;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } bdc_geom_t;

  typedef struct packed {
    logic cand;
    logic prim;
    logic enabled;
  } bdc_lane_ctl_t;

  typedef struct packed {
    logic              ok;
    logic              prim;
    logic [AREA_W-1:0] area;
    logic [IDX_W-1:0]  idx;
  } bdc_cand_t;

  // True when a (lower controller index) wins over b. Ties go to the
  // earlier controller unless the later one is the primary.
  function automatic logic bdc_beats(bdc_cand_t a, bdc_cand_t b);
    logic win;
    if (!a.ok) begin
      win = 1'b0;
    end else if (!b.ok) begin
      win = 1'b1;
    end else if (a.area != b.area) begin
      win = (a.area > b.area);
    end else begin
      win = a.prim || !b.prim;
    end
    return win;
  endfunction

endpackage

[hdl/bdc_lane.sv]
// One controller lane of the coverage selector: box edges, overlap spans
// and overlap area over three register stages. Depends on bdc_pkg.
`timescale 1ns / 1ps

module bdc_lane #(
  parameter int LANE = 0
) (
  input  logic                  clk,
  input  logic                  en,
  input  bdc_pkg::bdc_in_t      rect,
  input  bdc_pkg::bdc_geom_t    geom,
  input  bdc_pkg::bdc_lane_ctl_t ctl,
  output bdc_pkg::bdc_cand_t    cand
);
  import bdc_pkg::*;

  logic signed [EDGE_W-1:0] bx1, bx2, by1, by2, wid, hgt;
  logic signed [EDGE_W-1:0] rl, rr, rt, rb;
  logic signed [EDGE_W-1:0] ix1, ix2, iy1, iy2;
  logic signed [EDGE_W-1:0] s1_ix1, s1_ix2, s1_iy1, s1_iy2;
  bdc_lane_ctl_t            s1_ctl, s2_ctl;
  logic signed [EDGE_W-1:0] dx, dy;
  logic [COORD_W-1:0]       s2_w, s2_h;
  logic [AREA_W-1:0]        prod;

  // Stage 1: clip the controller box against the rectangle.
  always_comb begin
    wid = EDGE_W'(signed'({2'b00, geom.width}));
    hgt = EDGE_W'(signed'({2'b00, geom.height}));
    bx1 = ctl.enabled ? EDGE_W'(geom.x) : '0;
    by1 = ctl.enabled ? EDGE_W'(geom.y) : '0;
    bx2 = ctl.enabled ? bx1 + wid : '0;
    by2 = ctl.enabled ? by1 + hgt : '0;
    rl  = EDGE_W'(rect.rect_left);
    rr  = EDGE_W'(rect.rect_right);
    rt  = EDGE_W'(rect.rect_top);
    rb  = EDGE_W'(rect.rect_bottom);
    ix1 = (bx1 > rl) ? bx1 : rl;
    ix2 = (bx2 < rr) ? bx2 : rr;
    iy1 = (by1 > rt) ? by1 : rt;
    iy2 = (by2 < rb) ? by2 : rb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ix1 <= ix1;
      s1_ix2 <= ix2;
      s1_iy1 <= iy1;
      s1_iy2 <= iy2;
      s1_ctl <= ctl;
    end
  end

  // Stage 2: spans of the overlap, zero where the overlap is empty.
  // A positive span never exceeds 16 bits.
  assign dx = s1_ix2 - s1_ix1;
  assign dy = s1_iy2 - s1_iy1;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_w   <= (dx > 0) ? dx[COORD_W-1:0] : '0;
      s2_h   <= (dy > 0) ? dy[COORD_W-1:0] : '0;
      s2_ctl <= s1_ctl;
    end
  end

  // Stage 3: overlap area.
  assign prod = AREA_W'(s2_w) * AREA_W'(s2_h);

  always_ff @(posedge clk) begin
    if (en) begin
      cand.ok   <= s2_ctl.cand;
      cand.prim <= s2_ctl.prim;
      cand.area <= prod;
      cand.idx  <= IDX_W'(LANE);
    end
  end

endmodule

[hdl/best_display_by_coverage_core.sv]
// Channel   Handshake               Payload
// rect      rect_valid/rect_stall   bdc_in_t  (four signed 16-bit edges)
// result    result_valid/result_stall bdc_out_t (found, chosen_index)
// cfg       cfg_valid/cfg_ready     cfg_index, cfg_data (64 bits)
//
// One rectangle is taken every cycle unless the result is stalled; its result
// reaches the result port through the five pipeline registers (clip, span,
// multiply, pair compare, final compare), the first loaded at the transfer edge.
// Reset is synchronous and clears the valid bits and the configuration
// registers. A stalled result freezes the whole pipeline and stalls the rect
// channel in the same cycle. Depends on bdc_pkg, bdc_lane.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module best_display_by_coverage_core #(
  parameter int CRTC_COUNT = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             rect_valid,
  output logic                             rect_stall,
  input  bdc_pkg::bdc_in_t                 rect,
  output logic                             result_valid,
  input  logic                             result_stall,
  output bdc_pkg::bdc_out_t                result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bdc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bdc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bdc_pkg::*;

  bdc_geom_t              geom_q [CRTC_COUNT];
  logic [MAX_CRTC-1:0]    enabled_q, powered_q;
  logic [PRIMARY_W-1:0]   primary_q;
  logic                   owned_q;

  logic                   advance;
  logic                   v1, v2, v3, v4;
  bdc_cand_t              cand_s3 [MAX_CRTC];
  bdc_cand_t              w01, w23, win;
  logic                   found_next;

  assign cfg_ready  = 1'b1;
  assign advance    = !(result_valid && result_stall);
  assign rect_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CRTC_COUNT; c++) begin
        geom_q[c] <= '0;
      end
      enabled_q <= '0;
      powered_q <= '0;
      primary_q <= PRIMARY_NONE;
      owned_q   <= 1'b0;
    end else if (cfg_valid) begin
      for (int c = 0; c < CRTC_COUNT; c++) begin
        if (cfg_index == REG_GEOM_0 + CFG_INDEX_W'(c)) begin
          geom_q[c] <= bdc_geom_t'(cfg_data);
        end
      end
      case (cfg_index)
        REG_ENABLED: enabled_q <= cfg_data[MAX_CRTC-1:0];
        REG_POWERED: powered_q <= cfg_data[MAX_CRTC-1:0];
        REG_PRIMARY: primary_q <= cfg_data[PRIMARY_W-1:0];
        REG_OWNED:   owned_q   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  generate
    for (genvar c = 0; c < MAX_CRTC; c++) begin : g_lane
      if (c < CRTC_COUNT) begin : g_on
        bdc_lane_ctl_t ctl;
        assign ctl.cand    = owned_q && powered_q[c];
        assign ctl.prim    = (primary_q == PRIMARY_W'(c));
        assign ctl.enabled = enabled_q[c];
        bdc_lane #(.LANE(c)) u_lane (
          .clk  (clk),
          .en   (advance),
          .rect (rect),
          .geom (geom_q[c]),
          .ctl  (ctl),
          .cand (cand_s3[c])
        );
      end else begin : g_off
        assign cand_s3[c] = '0;
      end
    end
  endgenerate

  // Valid bits follow the lane stages; the whole pipe moves together.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      v1           <= rect_valid;
      v2           <= v1;
      v3           <= v2;
      v4           <= v3;
      result_valid <= v4;
    end
  end

  // Stage 4: pairwise winners.
  always_ff @(posedge clk) begin
    if (advance) begin
      w01 <= bdc_beats(cand_s3[0], cand_s3[1]) ? cand_s3[0] : cand_s3[1];
      w23 <= bdc_beats(cand_s3[2], cand_s3[3]) ? cand_s3[2] : cand_s3[3];
    end
  end

  // Stage 5: final winner. A zero area counts only for the primary.
  assign win        = bdc_beats(w01, w23) ? w01 : w23;
  assign found_next = win.ok && ((win.area != '0) || win.prim);

  always_ff @(posedge clk) begin
    if (advance) begin
      result.found        <= found_next;
      result.chosen_index <= found_next ? win.idx : '0;
    end
  end

  `ASSERT_CLK(a_pipe_moves, clk, rst, (v3 && advance) |=> v4)
  `ASSERT_CLK(a_idle_index, clk, rst,
              (result_valid && !result.found) |-> (result.chosen_index == '0))
  `ASSERT_NEVER(a_index_range, clk, rst,
                result_valid && result.found && (int'(result.chosen_index) >= CRTC_COUNT))

endmodule
